// File: rtl/keypad_press_debouncer_core_assert.svh
// Assertion macros shared by the debouncer checker.
`ifndef KEYPAD_PRESS_DEBOUNCER_CORE_ASSERT_SVH
`define KEYPAD_PRESS_DEBOUNCER_CORE_ASSERT_SVH

// Check a property on every clock edge outside of reset.
`define KPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define KPD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/kpd_pkg.sv
`default_nettype none
package kpd_pkg;

  // Matrix geometry defaults and limits
  localparam int ROW_COUNT_DEF = 4;
  localparam int COL_COUNT_DEF = 4;
  localparam int KEY_MAX       = 16;

  // Field widths
  localparam int LEVEL_W = 16;
  localparam int TIME_W  = 32;
  localparam int DELAY_W = 16;
  localparam int INDEX_W = 4;
  localparam int CHAR_W  = 7;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd50;

  typedef logic [INDEX_W-1:0] key_index_t;
  typedef logic [CHAR_W-1:0]  key_char_t;

  // Fixed letter map, row-major
  function automatic key_char_t kpd_key_char(input key_index_t idx);
    key_char_t ch;
    unique case (idx)
      4'd0:    ch = 7'd80;  // P
      4'd1:    ch = 7'd76;  // L
      4'd2:    ch = 7'd72;  // H
      4'd3:    ch = 7'd68;  // D
      4'd4:    ch = 7'd79;  // O
      4'd5:    ch = 7'd75;  // K
      4'd6:    ch = 7'd71;  // G
      4'd7:    ch = 7'd67;  // C
      4'd8:    ch = 7'd78;  // N
      4'd9:    ch = 7'd74;  // J
      4'd10:   ch = 7'd70;  // F
      4'd11:   ch = 7'd66;  // B
      4'd12:   ch = 7'd77;  // M
      4'd13:   ch = 7'd73;  // I
      4'd14:   ch = 7'd69;  // E
      default: ch = 7'd65;  // A
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// File: rtl/kpd_lane.sv
`default_nettype none
module kpd_lane (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic                        level,
  input  wire logic [kpd_pkg::TIME_W-1:0]  now_ms,
  input  wire logic [kpd_pkg::DELAY_W-1:0] delay_ms,
  output logic                             fire
);
  import kpd_pkg::*;

  logic              raw_prev_r, raw_prev_nxt;
  logic              stable_r, stable_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              late;

  // Elapsed time since press began, modulo 2^32
  assign elapsed = now_ms - start_r;
  assign late    = elapsed > {{(TIME_W-DELAY_W){1'b0}}, delay_ms};

  // A press that started on this scan still has raw_prev_r set, so it cannot fire
  assign fire = !level && !raw_prev_r && stable_r && late;

  // Next per-key state
  always_comb begin
    raw_prev_nxt = raw_prev_r;
    stable_nxt   = stable_r;
    start_nxt    = start_r;
    if (accept) begin
      if (level) begin
        raw_prev_nxt = 1'b1;
        stable_nxt   = 1'b1;
      end else begin
        if (raw_prev_r) begin
          start_nxt    = now_ms;
          raw_prev_nxt = 1'b0;
        end
        if (fire) begin
          stable_nxt = 1'b0;
        end
      end
    end
  end

  // Hold level state; clear to released on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_prev_r <= 1'b1;
      stable_r   <= 1'b1;
    end else begin
      raw_prev_r <= raw_prev_nxt;
      stable_r   <= stable_nxt;
    end
  end

  // Press timestamp
  always_ff @(posedge clk) begin
    start_r <= start_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/kpd_merge.sv
`default_nettype none
module kpd_merge #(
  parameter int KEY_TOTAL = kpd_pkg::KEY_MAX
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic [KEY_TOTAL-1:0]        fire_mask,
  output logic                             in_stall,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [kpd_pkg::INDEX_W-1:0]      out_key_index,
  output logic [kpd_pkg::CHAR_W-1:0]       out_key_char,
  output logic                             out_last_event
);
  import kpd_pkg::*;

  logic [KEY_TOTAL-1:0] mask_r, mask_nxt;
  logic [KEY_TOTAL-1:0] rest;
  logic                 single;
  logic                 out_take;
  key_index_t           low_idx;

  // Lowest pending key, row-major order
  always_comb begin
    low_idx = '0;
    for (int i = KEY_TOTAL - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_idx = INDEX_W'(i);
      end
    end
  end

  // Drop the lowest bit after its transfer
  assign rest   = mask_r & (mask_r - 1'b1);
  assign single = (rest == '0);

  assign out_valid      = |mask_r;
  assign out_key_index  = low_idx;
  assign out_key_char   = kpd_key_char(low_idx);
  assign out_last_event = single;
  assign out_take       = out_valid && !out_stall;

  // Take the next scan when no event is pending or as the last one of this scan goes out
  assign in_stall = out_valid && !(single && out_take);

  always_comb begin
    mask_nxt = mask_r;
    if (accept) begin
      mask_nxt = fire_mask;
    end else if (out_take) begin
      mask_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/keypad_press_debouncer_core.sv
`default_nettype none
// Key matrix press debouncer.
// Input channel (in_valid / in_stall): one matrix snapshot per transfer,
// in_scan_levels (bit row*COL_COUNT+col, 0 = pressed) and in_now_ms.
// Result channel (out_valid / out_stall): one press event per transfer with
// out_key_index, out_key_char and out_last_event on the final event of a scan.
// cfg_wr_en / cfg_wr_data write debounce_delay_ms (reset 50); write while idle.
// One lane per key checks its press timer in the cycle the snapshot transfers;
// the events found appear on the result side the next cycle, one per cycle
// while out_stall is low, in row-major order. The next scan is taken in the
// cycle the last event transfers, or whenever no event is pending.
// Reset: all keys released, no events pending, delay back to 50.
// While out_stall is high the current event holds, and in_stall rises once
// a scan's events are pending.
module keypad_press_debouncer_core #(
  parameter int ROW_COUNT = kpd_pkg::ROW_COUNT_DEF,
  parameter int COL_COUNT = kpd_pkg::COL_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [kpd_pkg::DELAY_W-1:0] cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [kpd_pkg::LEVEL_W-1:0] in_scan_levels,
  input  wire logic [kpd_pkg::TIME_W-1:0]  in_now_ms,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [kpd_pkg::INDEX_W-1:0]      out_key_index,
  output logic [kpd_pkg::CHAR_W-1:0]       out_key_char,
  output logic                             out_last_event
);
  import kpd_pkg::*;

  localparam int KEY_TOTAL = (ROW_COUNT * COL_COUNT < KEY_MAX) ?
                             ROW_COUNT * COL_COUNT : KEY_MAX;

  logic [DELAY_W-1:0]   delay_r;
  logic                 in_accept;
  logic [KEY_TOTAL-1:0] fire_mask;

  assign in_accept = in_valid && !in_stall;

  // Debounce delay register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
    end else if (cfg_wr_en) begin
      delay_r <= cfg_wr_data;
    end
  end

  // One lane per scanned key
  for (genvar k = 0; k < KEY_TOTAL; k++) begin : g_lane
    kpd_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .accept   (in_accept),
      .level    (in_scan_levels[k]),
      .now_ms   (in_now_ms),
      .delay_ms (delay_r),
      .fire     (fire_mask[k])
    );
  end

  // Serialize lane events
  kpd_merge #(
    .KEY_TOTAL (KEY_TOTAL)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .fire_mask      (fire_mask),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_index  (out_key_index),
    .out_key_char   (out_key_char),
    .out_last_event (out_last_event)
  );

endmodule
`default_nettype wire

// File: rtl/kpd_checker.sv
`default_nettype none
`include "keypad_press_debouncer_core_assert.svh"
module kpd_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_stall,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [kpd_pkg::INDEX_W-1:0] out_key_index,
  input  wire logic [kpd_pkg::CHAR_W-1:0]  out_key_char,
  input  wire logic                        out_last_event
);
  import kpd_pkg::*;

  // Stalled event holds
  `KPD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_key_index) && $stable(out_key_char) && $stable(out_last_event), "event changed under stall")

  // Letter follows the key map
  `KPD_ASSERT(a_char_map, out_valid |-> out_key_char == kpd_key_char(out_key_index), "key letter mismatch")

  // Events of one scan go out in rising key order without a gap
  `KPD_ASSERT(a_row_major, out_valid && !out_stall && !out_last_event |=> out_valid && (out_key_index > $past(out_key_index)), "events out of order")

  // No new scan while more events of this one wait
  `KPD_ASSERT(a_scan_block, out_valid && !out_last_event |-> in_stall, "scan taken mid-burst")

  // Reset drops pending events
  `KPD_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "event after reset")

endmodule

bind keypad_press_debouncer_core kpd_checker u_kpd_checker (.*);
`default_nettype wire

// File: verif/testbench.sv
`default_nettype none
module testbench;
  import kpd_pkg::*;

  localparam int KEY_TOTAL = (ROW_COUNT_DEF * COL_COUNT_DEF < KEY_MAX) ?
                             ROW_COUNT_DEF * COL_COUNT_DEF : KEY_MAX;
  // Row-major letter map, key 0 in the top byte
  localparam logic [16*8-1:0] KEY_MAP = "PLHDOKGCNJFBMIEA";
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic [LEVEL_W-1:0] levels;
    logic [TIME_W-1:0]  now;
  } scan_t;

  typedef struct {
    key_index_t idx;
    key_char_t  ch;
    logic       last;
  } press_event_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [DELAY_W-1:0]   cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LEVEL_W-1:0]   in_scan_levels = '1;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [INDEX_W-1:0]   out_key_index;
  logic [CHAR_W-1:0]    out_key_char;
  logic                 out_last_event;

  keypad_press_debouncer_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_scan_levels (in_scan_levels),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_index  (out_key_index),
    .out_key_char   (out_key_char),
    .out_last_event (out_last_event)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Debouncer state as the block should hold it
  logic [DELAY_W-1:0]   delay_ms = DELAY_RESET;
  logic [KEY_MAX-1:0]   raw_level = '1;
  logic [KEY_MAX-1:0]   stable_level = '1;
  logic [TIME_W-1:0]    press_start [KEY_MAX];

  scan_t                scan_queue [$];
  press_event_t         press_queue [$];
  int                   fail_count = 0;

  // Stimulus state for well-formed key activity
  logic [TIME_W-1:0]    sim_ms;
  logic [KEY_MAX-1:0]   held_keys = '0;

  // Sender, receiver and idling control
  logic                 in_took = 1'b0;
  scan_t                next_scan;
  int                   send_gap = 0;
  int                   stall_left = 0;
  int                   hold_left = 0;
  bit                   hold_arm = 1'b0;
  bit                   hold_used = 1'b0;
  bit                   calm = 1'b0;

  // Work out the press events one scan causes and queue them
  function automatic void predict_presses(input logic [LEVEL_W-1:0] levels,
                                          input logic [TIME_W-1:0] now);
    logic [KEY_MAX-1:0] hits;
    int                 last_k;
    press_event_t       ev;
    hits = '0;
    last_k = -1;
    for (int k = 0; k < KEY_TOTAL; k++) begin
      if (!levels[k]) begin
        if (raw_level[k]) begin
          press_start[k] = now;
          raw_level[k] = 1'b0;
        end
        if ((now - press_start[k]) > {16'd0, delay_ms} && stable_level[k]) begin
          stable_level[k] = 1'b0;
          hits[k] = 1'b1;
          last_k = k;
        end
      end else begin
        raw_level[k] = 1'b1;
        stable_level[k] = 1'b1;
      end
    end
    for (int k = 0; k < KEY_TOTAL; k++) begin
      if (hits[k]) begin
        ev.idx = k[INDEX_W-1:0];
        ev.ch = KEY_MAP[(15 - k) * 8 +: CHAR_W];
        ev.last = (k == last_k);
        press_queue.push_back(ev);
      end
    end
  endfunction

  // Sample both channels; check results before predicting new ones
  always @(posedge clk) begin
    press_event_t ev;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (press_queue.size() == 0) begin
          $error("unexpected press event: key_index=%0d key_char=%0d last_event=%0b",
                 out_key_index, out_key_char, out_last_event);
          fail_count++;
        end else begin
          ev = press_queue.pop_front();
          if (out_key_index !== ev.idx) begin
            $error("key_index: expected %0d, actual %0d", ev.idx, out_key_index);
            fail_count++;
          end
          if (out_key_char !== ev.ch) begin
            $error("key_char: expected %0d, actual %0d", ev.ch, out_key_char);
            fail_count++;
          end
          if (out_last_event !== ev.last) begin
            $error("last_event: expected %0b, actual %0b", ev.last, out_last_event);
            fail_count++;
          end
        end
      end
      in_took = in_valid && !in_stall;
      if (in_took) predict_presses(in_scan_levels, in_now_ms);
    end
  end

  // Offer pending scans; hold the payload until the transfer
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (scan_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 10) - 1;
        in_valid <= 1'b0;
      end else begin
        next_scan = scan_queue.pop_front();
        in_valid <= 1'b1;
        in_scan_levels <= next_scan.levels;
        in_now_ms <= next_scan.now;
      end
    end
  end

  // Stall the result side in bursts, plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_arm && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic add_scan(input logic [LEVEL_W-1:0] levels, input logic [TIME_W-1:0] now);
    scan_t s;
    s.levels = levels;
    s.now = now;
    scan_queue.push_back(s);
  endtask

  // Keys go down and up with time moving forward; some scans are pure noise
  task automatic add_random_scans(input int count);
    int span;
    span = delay_ms / 2 + 8;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_scan(LEVEL_W'($urandom_range(0, 16'hFFFF)), $urandom);
      end else begin
        sim_ms = sim_ms + $urandom_range(0, span);
        for (int k = 0; k < KEY_MAX; k++)
          if ($urandom_range(0, 6) == 0) held_keys[k] = ~held_keys[k];
        add_scan(~held_keys, sim_ms);
      end
    end
  endtask

  task automatic wait_drained();
    while (scan_queue.size() != 0 || in_valid || press_queue.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delay(input logic [DELAY_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    delay_ms = value;
  endtask

  initial begin
    for (int k = 0; k < KEY_MAX; k++) press_start[k] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset delay: simultaneous presses, held key, bounce, time wrap, all keys
    add_scan(16'hFFFF, 32'd0);
    add_scan(16'h7FFE, 32'd100);
    add_scan(16'h7FFE, 32'd150);
    add_scan(16'h7FFE, 32'd151);
    add_scan(16'h7FFE, 32'd500);
    add_scan(16'h0000, 32'd600);
    add_scan(16'h0000, 32'd651);
    add_scan(16'hFFFF, 32'd700);
    add_scan(16'hFFDF, 32'd1000);
    add_scan(16'hFFFF, 32'd1010);
    add_scan(16'hFFDF, 32'd1020);
    add_scan(16'hFFDF, 32'd1060);
    add_scan(16'hFFDF, 32'd1071);
    add_scan(16'hFFFF, 32'd1100);
    add_scan(16'h0000, 32'hFFFF_FFF0);
    add_scan(16'h0000, 32'h0000_0023);
    add_scan(16'hFFFF, 32'h0000_0030);
    wait_drained();

    // Zero delay: report one millisecond after the press begins
    write_delay(16'd0);
    add_scan(16'hFFF7, 32'd5000);
    add_scan(16'hFFF7, 32'd5000);
    add_scan(16'hFFF7, 32'd5001);
    add_scan(16'hFFFF, 32'd5002);
    sim_ms = $urandom;
    held_keys = '0;
    add_random_scans(80);
    wait_drained();

    // Longest delay, across the time wrap
    write_delay(16'hFFFF);
    add_scan(16'hEFFF, 32'hFFFF_8000);
    add_scan(16'hEFFF, 32'hFFFF_8000 + 32'd65535);
    add_scan(16'hEFFF, 32'hFFFF_8000 + 32'd65536);
    add_scan(16'hFFFF, 32'h0000_9000);
    sim_ms = 32'hFFF0_0000;
    held_keys = '0;
    add_random_scans(80);
    wait_drained();

    // Random delay, with the long receiver hold-off
    write_delay(DELAY_W'($urandom_range(1, 2000)));
    add_random_scans(100);
    hold_arm = 1'b1;
    wait_drained();

    // Back to the reset delay, no idling on either side
    write_delay(DELAY_RESET);
    calm = 1'b1;
    add_random_scans(85);
    wait_drained();
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Give up if the run stalls
  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
